// ===== hw/rtl/iba_pkg.sv =====
// Shared constants, codes and the command type for the inode and block allocator.
`default_nettype none
package iba_pkg;

	localparam int INODE_COUNT_DEF = 128;
	localparam int WORD_BITS       = 16;
	localparam int COUNT_W         = 16;

	localparam logic [15:0] CAP_RESET   = 16'd973;
	localparam logic [10:0] DIRECT_MAX  = 11'd12;
	localparam logic [10:0] SINGLE_BASE = 11'd11;
	localparam logic [10:0] SINGLE_LIM  = 11'd268;
	localparam logic [10:0] DOUBLE_BASE = 11'd266;
	localparam logic [10:0] DOUBLE_LIM  = 11'd524;
	localparam logic [8:0]  SINGLE_MAX  = 9'd257;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_SHORT    = 2'd1;
	localparam logic [1:0] ST_NO_INODE = 2'd2;
	localparam logic [1:0] ST_INVALID  = 2'd3;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef struct packed {
		logic load_budget;
		logic accept;
		logic execute;
	} iba_cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/iba_ram.sv =====
// Generic single-port RAM with a registered read.
`default_nettype none
module iba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/iba_ctrl.sv =====
// Controller state machine that sequences budget load, request capture and execution.
`default_nettype none
module iba_ctrl import iba_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	output iba_cmd_t  cmd
);

	localparam logic [1:0] S_INIT = 2'd0;
	localparam logic [1:0] S_IDLE = 2'd1;
	localparam logic [1:0] S_EXEC = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: state_d = S_IDLE;
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: state_d = S_IDLE;
			default: state_d = S_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy            = (state_q != S_IDLE);
	assign cmd.load_budget = (state_q == S_INIT);
	assign cmd.accept      = (state_q == S_IDLE) && start;
	assign cmd.execute     = (state_q == S_EXEC);

endmodule
`default_nettype wire

// ===== hw/rtl/iba_datapath.sv =====
// Datapath: block split, inode bitmap search, block-count memory and free budget.
`default_nettype none
module iba_datapath import iba_pkg::*; #(
	parameter int INODE_COUNT = INODE_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire iba_cmd_t    cmd,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        mode,
	input  wire logic [19:0] file_size,
	input  wire logic [6:0]  inode_index,
	output logic             done,
	output logic [1:0]       status,
	output logic [6:0]       inode_granted,
	output logic [3:0]       direct_blocks,
	output logic [8:0]       single_indirect_blocks,
	output logic [9:0]       double_indirect_blocks,
	output logic [15:0]      blocks_remaining
);

	localparam int AW    = $clog2(INODE_COUNT);
	localparam int NW    = (INODE_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int WW    = (NW > 1) ? $clog2(NW) : 1;
	localparam int BW    = $clog2(WORD_BITS);
	localparam int PADW  = NW * WORD_BITS;

	logic [15:0]            cap_q;
	logic [15:0]            free_q;
	logic [INODE_COUNT-1:0] used_q;
	logic [PADW-1:0]        used_pad;

	logic                   mode_s1;
	logic                   zero_s1;
	logic                   idx_ok_s1;
	logic [AW-1:0]          idx_s1;
	logic [3:0]             d_s1;
	logic [8:0]             s_s1;
	logic [9:0]             dd_s1;
	logic [10:0]            total_s1;
	logic [WW-1:0]          word_s1;
	logic                   any_free_s1;

	logic [10:0]            n_blk;
	logic [3:0]             d_c;
	logic [8:0]             s_c;
	logic [9:0]             dd_c;
	logic [WW-1:0]          word_c;
	logic                   any_free_c;

	logic [WORD_BITS-1:0]   sel_word;
	logic [BW-1:0]          bit_c;
	logic [AW-1:0]          found;
	logic [WW+BW-1:0]       found_full;

	logic                   ram_we;
	logic [AW-1:0]          ram_addr;
	logic [COUNT_W-1:0]     ram_rdata;
	logic [16:0]            sum_free;

	logic [1:0]             st_c;
	logic [6:0]             granted_c;
	logic [3:0]             dir_c;
	logic [8:0]             sgl_c;
	logic [9:0]             dbl_c;
	logic [15:0]            left_c;

	always_comb begin
		used_pad = '1;
		used_pad[INODE_COUNT-1:0] = used_q;
	end

	always_comb begin
		n_blk = {1'b0, file_size[19:10]} + {10'd0, |file_size[9:0]};
		d_c   = 4'd0;
		s_c   = 9'd0;
		dd_c  = 10'd0;
		if (n_blk <= DIRECT_MAX) begin
			d_c = n_blk[3:0];
		end else begin
			d_c = DIRECT_MAX[3:0];
			if (n_blk > SINGLE_LIM) begin
				s_c  = SINGLE_MAX;
				dd_c = 10'(n_blk - DOUBLE_BASE) + {9'd0, (n_blk > DOUBLE_LIM)};
			end else begin
				s_c = 9'(n_blk - SINGLE_BASE);
			end
		end
	end

	always_comb begin
		word_c     = '0;
		any_free_c = 1'b0;
		for (int w = NW - 1; w >= 0; w--) begin
			if (!(&used_pad[w*WORD_BITS +: WORD_BITS])) begin
				word_c     = WW'(w);
				any_free_c = 1'b1;
			end
		end
	end

	always_comb begin
		sel_word = used_pad[word_s1*WORD_BITS +: WORD_BITS];
		bit_c    = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (!sel_word[b]) begin
				bit_c = BW'(b);
			end
		end
		found_full = {word_s1, bit_c};
		found      = found_full[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_s1     <= mode;
			zero_s1     <= (file_size == 20'd0);
			idx_ok_s1   <= (32'(inode_index) < INODE_COUNT);
			idx_s1      <= AW'(inode_index);
			d_s1        <= d_c;
			s_s1        <= s_c;
			dd_s1       <= dd_c;
			total_s1    <= 11'(d_c) + 11'(s_c) + 11'(dd_c);
			word_s1     <= word_c;
			any_free_s1 <= any_free_c;
		end
	end

	assign ram_we   = cmd.execute && (mode_s1 == MODE_ALLOC) && !zero_s1 &&
	                  ({5'd0, total_s1} <= free_q) && any_free_s1;
	assign ram_addr = cmd.execute ? found : AW'(inode_index);

	iba_ram #(
		.WIDTH(COUNT_W),
		.DEPTH(INODE_COUNT)
	) u_count_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata({5'd0, total_s1}),
		.rdata(ram_rdata)
	);

	assign sum_free = {1'b0, free_q} + {1'b0, ram_rdata};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= CAP_RESET;
			used_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= cmd.execute;
			if (cmd.load_budget) begin
				free_q <= cap_q;
			end else if (cmd.execute) begin
				if (mode_s1 == MODE_ALLOC) begin
					if (ram_we) begin
						used_q[found] <= 1'b1;
						free_q        <= free_q - {5'd0, total_s1};
					end
				end else if (idx_ok_s1 && used_q[idx_s1]) begin
					used_q[idx_s1] <= 1'b0;
					free_q         <= sum_free[16] ? 16'hFFFF : sum_free[15:0];
				end
			end
		end
	end

	always_comb begin
		st_c      = ST_OK;
		granted_c = 7'd0;
		dir_c     = 4'd0;
		sgl_c     = 9'd0;
		dbl_c     = 10'd0;
		left_c    = free_q;
		if (mode_s1 == MODE_ALLOC) begin
			if (zero_s1) begin
				st_c = ST_INVALID;
			end else if ({5'd0, total_s1} > free_q) begin
				st_c = ST_SHORT;
			end else if (!any_free_s1) begin
				st_c = ST_NO_INODE;
			end else begin
				granted_c = 7'(found);
				dir_c     = d_s1;
				sgl_c     = s_s1;
				dbl_c     = dd_s1;
				left_c    = free_q - {5'd0, total_s1};
			end
		end else begin
			if (idx_ok_s1 && used_q[idx_s1]) begin
				granted_c = 7'(idx_s1);
				left_c    = sum_free[16] ? 16'hFFFF : sum_free[15:0];
			end else begin
				st_c = ST_INVALID;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			status                 <= st_c;
			inode_granted          <= granted_c;
			direct_blocks          <= dir_c;
			single_indirect_blocks <= sgl_c;
			double_indirect_blocks <= dbl_c;
			blocks_remaining       <= left_c;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/inode_and_block_allocator.sv =====
// Inode and block allocator: a request is taken from start and ends with the done strobe.
// The request is captured at the accepting edge; the result is registered, with done high,
// at the end of the execute state. No new request is taken before then: busy is high during
// the bitmap update and block-count memory write. A new request may start while done is high.
// Reset clears the inode bitmap, loads the capacity register with 973 and copies it into the
// free budget in the init state after reset, while busy is high; done cannot be held off.
`default_nettype none
module inode_and_block_allocator import iba_pkg::*; #(
	parameter int INODE_COUNT = INODE_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	output logic             done,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        mode,
	input  wire logic [19:0] file_size,
	input  wire logic [6:0]  inode_index,
	output logic [1:0]       status,
	output logic [6:0]       inode_granted,
	output logic [3:0]       direct_blocks,
	output logic [8:0]       single_indirect_blocks,
	output logic [9:0]       double_indirect_blocks,
	output logic [15:0]      blocks_remaining
);

	iba_cmd_t cmd;

	iba_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd)
	);

	iba_datapath #(
		.INODE_COUNT(INODE_COUNT)
	) u_datapath (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cmd                   (cmd),
		.cfg_we                (cfg_we),
		.cfg_wdata             (cfg_wdata),
		.mode                  (mode),
		.file_size             (file_size),
		.inode_index           (inode_index),
		.done                  (done),
		.status                (status),
		.inode_granted         (inode_granted),
		.direct_blocks         (direct_blocks),
		.single_indirect_blocks(single_indirect_blocks),
		.double_indirect_blocks(double_indirect_blocks),
		.blocks_remaining      (blocks_remaining)
	);

endmodule
`default_nettype wire
